// ===== rtl/msrsm_pkg.sv =====
// Shared widths, codes and types for the multistage ring slot manager.
`timescale 1ns / 1ps
`default_nettype none
package msrsm_pkg;

   localparam int StagesDefault = 4;
   localparam int DepthDefault  = 256;

   localparam int StageW   = 2;
   localparam int StatusW  = 2;
   localparam int SlotW    = 8;
   localparam int FreeW    = 9;
   localparam int OffsetW  = 16;
   localparam int CfgW     = 4;
   localparam int CsrIdxW  = 1;
   localparam int RingLog2Max = 8;

   localparam logic [StatusW-1:0] STATUS_OK      = 2'd0;
   localparam logic [StatusW-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [StatusW-1:0] STATUS_NO_HELD = 2'd2;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [CsrIdxW-1:0] CSR_SLOTS_LOG2      = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_SLOT_BYTES_LOG2 = 1'd1;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

   function automatic logic [CfgW-1:0] sat_log2(input logic [CfgW-1:0] v,
                                                input logic [CfgW-1:0] cap);
      sat_log2 = (v > cap) ? cap : v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/multistage_ring_slot_manager.sv =====
// Top level of the multistage ring slot manager: sequencer plus pointer datapath.
// A transferred request is loaded, executed in the EXEC state, and its result strobe comes from a register.
// A new request is not taken while busy; start is taken again in the result cycle.
// The single execute state reads and updates the per-stage pointer registers.
// Synchronous active-high reset clears pointers, sets ring to the largest size, offset shift 0.
// Results cannot be stalled; a configuration write clears all pointers.
`timescale 1ns / 1ps
`default_nettype none
module multistage_ring_slot_manager #(
   parameter int STAGES = msrsm_pkg::StagesDefault,
   parameter int DEPTH  = msrsm_pkg::DepthDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic                              req_type,
   input  wire logic [msrsm_pkg::StageW-1:0]      req_stage,
   output      logic                              rsp_valid,
   output      logic [msrsm_pkg::StatusW-1:0]     rsp_status,
   output      logic [msrsm_pkg::SlotW-1:0]       rsp_slot_index,
   output      logic [msrsm_pkg::OffsetW-1:0]     rsp_byte_offset,
   input  wire logic                              csr_wr_en,
   input  wire logic [msrsm_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [msrsm_pkg::CfgW-1:0]        csr_wdata
);

   msrsm_pkg::ctrl_cmd_type cmd;

   msrsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   msrsm_datapath #(
      .STAGES (STAGES),
      .DEPTH  (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_stage       (req_stage),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_byte_offset (rsp_byte_offset)
   );

endmodule
`default_nettype wire

// ===== rtl/msrsm_ctrl.sv =====
// Request sequencer: accepts a transfer, runs the execute state, strobes the result.
`timescale 1ns / 1ps
`default_nettype none
module msrsm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   output      logic                  rsp_valid,
   output      msrsm_pkg::ctrl_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/msrsm_datapath.sv =====
// Slot pointer state, configuration registers and result registers.
`timescale 1ns / 1ps
`default_nettype none
module msrsm_datapath #(
   parameter int STAGES = msrsm_pkg::StagesDefault,
   parameter int DEPTH  = msrsm_pkg::DepthDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire msrsm_pkg::ctrl_cmd_type           cmd,
   input  wire logic                              req_type,
   input  wire logic [msrsm_pkg::StageW-1:0]      req_stage,
   input  wire logic                              csr_wr_en,
   input  wire logic [msrsm_pkg::CsrIdxW-1:0]     csr_index,
   input  wire logic [msrsm_pkg::CfgW-1:0]        csr_wdata,
   output      logic [msrsm_pkg::StatusW-1:0]     rsp_status,
   output      logic [msrsm_pkg::SlotW-1:0]       rsp_slot_index,
   output      logic [msrsm_pkg::OffsetW-1:0]     rsp_byte_offset
);

   localparam int SW        = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int DepthLog2 = $clog2(DEPTH + 1) - 1;
   localparam int RingCapI  = (DepthLog2 < msrsm_pkg::RingLog2Max) ?
                              DepthLog2 : msrsm_pkg::RingLog2Max;
   localparam logic [msrsm_pkg::CfgW-1:0] RingCap  = msrsm_pkg::CfgW'(RingCapI);
   localparam logic [msrsm_pkg::CfgW-1:0] BytesCap =
      msrsm_pkg::CfgW'(msrsm_pkg::RingLog2Max);
   localparam logic [SW-1:0] TailIdx = SW'(STAGES - 1);

   logic                             req_type_ff;
   logic [msrsm_pkg::StageW-1:0]     req_stage_ff;
   logic [msrsm_pkg::CfgW-1:0]       ring_log2_ff, ring_log2_in;
   logic [msrsm_pkg::CfgW-1:0]       bytes_log2_ff, bytes_log2_in;
   logic [STAGES-1:0]                held_valid_ff, held_valid_in;
   logic [msrsm_pkg::SlotW-1:0]      held_slot_ff [STAGES];
   logic [msrsm_pkg::SlotW-1:0]      held_slot_in [STAGES];
   logic [msrsm_pkg::SlotW-1:0]      next_slot_ff [STAGES];
   logic [msrsm_pkg::SlotW-1:0]      next_slot_in [STAGES];
   logic [msrsm_pkg::FreeW-1:0]      free_count_ff, free_count_in;
   logic [msrsm_pkg::StatusW-1:0]    status_ff, status_in;
   logic [msrsm_pkg::SlotW-1:0]      slot_ff, slot_in;
   logic [msrsm_pkg::OffsetW-1:0]    offset_ff, offset_in;

   logic [msrsm_pkg::FreeW-1:0]      ring_size, ring_size_in;
   logic [msrsm_pkg::SlotW-1:0]      ring_mask;
   logic [SW-1:0]                    idx, idx_prev;
   logic                             in_range, refuse, tail_free;

   assign idx       = SW'(req_stage_ff);
   assign idx_prev  = idx - SW'(1);
   assign in_range  = (32'(req_stage_ff) < STAGES);
   assign ring_size = msrsm_pkg::FreeW'(1) << ring_log2_ff;
   assign ring_mask = msrsm_pkg::SlotW'(ring_size - msrsm_pkg::FreeW'(1));
   assign ring_size_in = msrsm_pkg::FreeW'(1) << ring_log2_in;
   assign tail_free = (idx == TailIdx) && (free_count_ff < ring_size);

   always_comb begin
      ring_log2_in  = ring_log2_ff;
      bytes_log2_in = bytes_log2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            msrsm_pkg::CSR_SLOTS_LOG2:
               ring_log2_in = msrsm_pkg::sat_log2(csr_wdata, RingCap);
            msrsm_pkg::CSR_SLOT_BYTES_LOG2:
               bytes_log2_in = msrsm_pkg::sat_log2(csr_wdata, BytesCap);
            default: ;
         endcase
      end
   end

   always_comb begin
      held_valid_in = held_valid_ff;
      held_slot_in  = held_slot_ff;
      next_slot_in  = next_slot_ff;
      free_count_in = free_count_ff;
      status_in     = msrsm_pkg::STATUS_REFUSED;
      slot_in       = '0;
      refuse        = 1'b1;
      if (idx == '0) begin
         refuse = (free_count_ff == '0);
      end else begin
         refuse = (held_valid_ff[idx_prev] && next_slot_ff[idx] == held_slot_ff[idx_prev]) ||
                  (next_slot_ff[idx] == next_slot_ff[idx_prev]);
      end
      if (csr_wr_en) begin
         held_valid_in = '0;
         for (int k = 0; k < STAGES; k++) begin
            held_slot_in[k] = '0;
            next_slot_in[k] = '0;
         end
         free_count_in = ring_size_in;
      end else if (cmd.exec && in_range) begin
         if (req_type_ff == msrsm_pkg::REQ_RELEASE) begin
            if (!held_valid_ff[idx]) begin
               status_in = msrsm_pkg::STATUS_NO_HELD;
            end else begin
               held_valid_in[idx] = 1'b0;
               if (tail_free) begin
                  free_count_in = free_count_ff + msrsm_pkg::FreeW'(1);
               end
               status_in = msrsm_pkg::STATUS_OK;
            end
         end else if (!refuse) begin
            if (held_valid_ff[idx] && tail_free) begin
               free_count_in = free_count_ff + msrsm_pkg::FreeW'(1);
            end
            if (idx == '0) begin
               free_count_in = free_count_ff - msrsm_pkg::FreeW'(1);
            end
            held_valid_in[idx] = 1'b1;
            held_slot_in[idx]  = next_slot_ff[idx];
            next_slot_in[idx]  = (next_slot_ff[idx] + msrsm_pkg::SlotW'(1)) & ring_mask;
            status_in          = msrsm_pkg::STATUS_OK;
            slot_in            = next_slot_ff[idx];
         end
      end
      offset_in = msrsm_pkg::OffsetW'(slot_in) << bytes_log2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_log2_ff  <= RingCap;
         bytes_log2_ff <= '0;
         held_valid_ff <= '0;
         for (int k = 0; k < STAGES; k++) begin
            held_slot_ff[k] <= '0;
            next_slot_ff[k] <= '0;
         end
         free_count_ff <= msrsm_pkg::FreeW'(1) << RingCap;
      end else begin
         ring_log2_ff  <= ring_log2_in;
         bytes_log2_ff <= bytes_log2_in;
         held_valid_ff <= held_valid_in;
         held_slot_ff  <= held_slot_in;
         next_slot_ff  <= next_slot_in;
         free_count_ff <= free_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff  <= req_type;
         req_stage_ff <= req_stage;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_slot_index  = slot_ff;
   assign rsp_byte_offset = offset_ff;

endmodule
`default_nettype wire

// ===== rtl/msrsm_checker.sv =====
// Port-level checks for the multistage ring slot manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module msrsm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic [msrsm_pkg::StatusW-1:0]     rsp_status,
   input wire logic [msrsm_pkg::SlotW-1:0]       rsp_slot_index,
   input wire logic [msrsm_pkg::OffsetW-1:0]     rsp_byte_offset
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer accepted but busy not raised");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after transfer");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != msrsm_pkg::STATUS_OK |->
         rsp_slot_index == '0 && rsp_byte_offset == '0)
      else $error("nonzero slot on a failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == msrsm_pkg::STATUS_OK ||
                    rsp_status == msrsm_pkg::STATUS_REFUSED ||
                    rsp_status == msrsm_pkg::STATUS_NO_HELD)
      else $error("undefined status code");

endmodule

bind multistage_ring_slot_manager msrsm_checker u_msrsm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_slot_index  (rsp_slot_index),
   .rsp_byte_offset (rsp_byte_offset)
);
`default_nettype wire

// ===== verif/multistage_ring_slot_manager_tb.sv =====
// Self-checking testbench for the multistage ring slot manager.
`timescale 1ns / 1ps
module multistage_ring_slot_manager_tb;

   localparam int Stages    = msrsm_pkg::StagesDefault;
   localparam int DepthLog2 = $clog2(msrsm_pkg::DepthDefault);
   localparam int StallLimit = 1000;

   typedef struct packed {
      logic [msrsm_pkg::StatusW-1:0] status;
      logic [msrsm_pkg::SlotW-1:0]   slot;
      logic [msrsm_pkg::OffsetW-1:0] offset;
   } slot_grant_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_type = msrsm_pkg::REQ_ACQUIRE;
   logic [msrsm_pkg::StageW-1:0]    req_stage = '0;
   logic                            rsp_valid;
   logic [msrsm_pkg::StatusW-1:0]   rsp_status;
   logic [msrsm_pkg::SlotW-1:0]     rsp_slot_index;
   logic [msrsm_pkg::OffsetW-1:0]   rsp_byte_offset;
   logic                            csr_wr_en = 1'b0;
   logic [msrsm_pkg::CsrIdxW-1:0]   csr_index = msrsm_pkg::CSR_SLOTS_LOG2;
   logic [msrsm_pkg::CfgW-1:0]      csr_wdata = '0;

   // shadow of the block's configuration and pointers
   logic [msrsm_pkg::CfgW-1:0]  cfg_slots_log2;
   logic [msrsm_pkg::CfgW-1:0]  cfg_slot_bytes_log2;
   logic                        stage_holds[Stages];
   logic [msrsm_pkg::SlotW-1:0] stage_held_slot[Stages];
   logic [msrsm_pkg::SlotW-1:0] stage_next_slot[Stages];
   logic [msrsm_pkg::FreeW-1:0] free_slots;

   slot_grant_type pending_grants[$];
   int             errors = 0;
   int             sender_idle_pct = 0;
   int             quiet_cycles = 0;

   multistage_ring_slot_manager dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_stage       (req_stage),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_byte_offset (rsp_byte_offset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int ring_bits();
      int b;
      b = cfg_slots_log2;
      if (b > msrsm_pkg::RingLog2Max) b = msrsm_pkg::RingLog2Max;
      if (b > DepthLog2) b = DepthLog2;
      return b;
   endfunction

   function automatic logic [msrsm_pkg::FreeW-1:0] ring_slots();
      return msrsm_pkg::FreeW'(1) << ring_bits();
   endfunction

   function automatic void clear_ring();
      for (int i = 0; i < Stages; i++) begin
         stage_holds[i] = 1'b0;
         stage_held_slot[i] = '0;
         stage_next_slot[i] = '0;
      end
      free_slots = ring_slots();
   endfunction

   function automatic void drop_slot(input int s);
      stage_holds[s] = 1'b0;
      if (s == Stages - 1 && free_slots < ring_slots()) free_slots = free_slots + 1'b1;
   endfunction

   function automatic slot_grant_type grant_for_request(
      input logic rtype, input logic [msrsm_pkg::StageW-1:0] stg);
      slot_grant_type g;
      logic refuse;
      int s;
      int ahead;
      int shift;
      logic [msrsm_pkg::SlotW-1:0] mask;
      g.status = msrsm_pkg::STATUS_REFUSED;
      g.slot = '0;
      g.offset = '0;
      s = stg;
      ahead = s - 1;
      shift = (cfg_slot_bytes_log2 > msrsm_pkg::RingLog2Max) ?
              msrsm_pkg::RingLog2Max : cfg_slot_bytes_log2;
      mask = msrsm_pkg::SlotW'(ring_slots() - 1'b1);
      if (s < Stages) begin
         if (rtype == msrsm_pkg::REQ_RELEASE) begin
            if (!stage_holds[s]) begin
               g.status = msrsm_pkg::STATUS_NO_HELD;
            end else begin
               drop_slot(s);
               g.status = msrsm_pkg::STATUS_OK;
            end
         end else begin
            if (s == 0)
               refuse = (free_slots == 0);
            else
               refuse = (stage_holds[ahead] && stage_next_slot[s] == stage_held_slot[ahead]) ||
                        (stage_next_slot[s] == stage_next_slot[ahead]);
            if (!refuse) begin
               if (stage_holds[s]) drop_slot(s);
               stage_held_slot[s] = stage_next_slot[s];
               stage_holds[s] = 1'b1;
               if (s == 0 && free_slots > 0) free_slots = free_slots - 1'b1;
               stage_next_slot[s] = (stage_next_slot[s] + 1'b1) & mask;
               g.status = msrsm_pkg::STATUS_OK;
               g.slot = stage_held_slot[s];
               g.offset = {{(msrsm_pkg::OffsetW-msrsm_pkg::SlotW){1'b0}}, g.slot} << shift;
            end
         end
      end
      return g;
   endfunction

   task automatic send_request(input logic rtype, input logic [msrsm_pkg::StageW-1:0] stg);
      start <= 1'b1;
      req_type <= rtype;
      req_stage <= stg;
      do @(posedge clock); while (busy !== 1'b0);
      pending_grants.push_back(grant_for_request(rtype, stg));
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_results();
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [msrsm_pkg::CsrIdxW-1:0] idx,
                            input logic [msrsm_pkg::CfgW-1:0] val,
                            input bit last);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == msrsm_pkg::CSR_SLOTS_LOG2) cfg_slots_log2 = val;
      else cfg_slot_bytes_log2 = val;
      clear_ring();
      if (last) csr_wr_en <= 1'b0;
   endtask

   task automatic program_ring(input logic [msrsm_pkg::CfgW-1:0] slots_log2,
                               input logic [msrsm_pkg::CfgW-1:0] bytes_log2);
      wait_results();
      if ($urandom_range(0, 1)) begin
         write_csr(msrsm_pkg::CSR_SLOTS_LOG2, slots_log2, 1'b0);
         write_csr(msrsm_pkg::CSR_SLOT_BYTES_LOG2, bytes_log2, 1'b1);
      end else begin
         write_csr(msrsm_pkg::CSR_SLOT_BYTES_LOG2, bytes_log2, 1'b0);
         write_csr(msrsm_pkg::CSR_SLOTS_LOG2, slots_log2, 1'b1);
      end
   endtask

   // reset configuration: refusals, releases with nothing held, a short handoff chain
   task automatic test_reset_state();
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd2);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd3);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd2);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd3);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd3);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd0);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
   endtask

   // single-slot ring, saturated registers, a two-slot ring wrapping
   task automatic test_register_extremes();
      program_ring(4'd0, 4'd15);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      program_ring(4'd15, 4'd8);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      program_ring(4'd1, 4'd3);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd0);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd1);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd2);
      send_request(msrsm_pkg::REQ_ACQUIRE, 2'd3);
      send_request(msrsm_pkg::REQ_RELEASE, 2'd3);
   endtask

   // mostly in-order stage sweeps with random holes and releases, some noise
   task automatic run_traffic(input int count);
      int left;
      left = count;
      while (left > 0) begin
         if ($urandom_range(0, 99) < 70) begin
            for (int k = 0; k < Stages && left > 0; k++) begin
               if ($urandom_range(0, 4) != 0) begin
                  send_request(msrsm_pkg::REQ_ACQUIRE, msrsm_pkg::StageW'(k));
                  left--;
               end
               if (left > 0 && $urandom_range(0, 3) == 0) begin
                  send_request(msrsm_pkg::REQ_RELEASE, msrsm_pkg::StageW'(k));
                  left--;
               end
            end
         end else begin
            send_request(logic'($urandom_range(0, 1)),
                         msrsm_pkg::StageW'($urandom_range(0, 3)));
            left--;
         end
         if ($urandom_range(0, 39) == 0) wait_results();
      end
   endtask

   task automatic test_random_traffic();
      int idle_pct[3];
      idle_pct = '{18, 81, 0};
      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_pct[p];
         for (int j = 0; j < 4; j++) begin
            if (j == 0) begin
               case ($urandom_range(0, 3))
                  0: program_ring(4'd0, 4'd15);
                  1: program_ring(4'd8, 4'd8);
                  2: program_ring(4'd9, 4'd0);
                  default: program_ring(4'd15, msrsm_pkg::CfgW'($urandom_range(0, 15)));
               endcase
            end else begin
               program_ring(msrsm_pkg::CfgW'($urandom_range(1, 4)),
                            msrsm_pkg::CfgW'($urandom_range(0, 15)));
            end
            run_traffic(60);
         end
      end
      wait_results();
   endtask

   always @(posedge clock) begin
      slot_grant_type exp_grant;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result, status %0d slot %0d offset %0d", $time,
                     rsp_status, rsp_slot_index, rsp_byte_offset);
            errors++;
         end else begin
            exp_grant = pending_grants.pop_front();
            if (rsp_status !== exp_grant.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_grant.status, rsp_status);
               errors++;
            end
            if (rsp_slot_index !== exp_grant.slot) begin
               $display("%0t: slot_index expected %0d actual %0d", $time,
                        exp_grant.slot, rsp_slot_index);
               errors++;
            end
            if (rsp_byte_offset !== exp_grant.offset) begin
               $display("%0t: byte_offset expected %0d actual %0d", $time,
                        exp_grant.offset, rsp_byte_offset);
               errors++;
            end
         end
      end
   end

   // no transfer on either side for too long ends the run
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      cfg_slots_log2 = msrsm_pkg::CfgW'(msrsm_pkg::RingLog2Max);
      cfg_slot_bytes_log2 = '0;
      clear_ring();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_extremes();
      test_random_traffic();
      if (pending_grants.size() != 0) errors++;
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/msrsm_pkg.sv
rtl/msrsm_ctrl.sv
rtl/msrsm_datapath.sv
rtl/multistage_ring_slot_manager.sv
rtl/msrsm_checker.sv
verif/multistage_ring_slot_manager_tb.sv
